### sv/lisr_pkg.sv
package lisr_pkg;

	// Field and state widths.
	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned AUDIO_W  = 16;
	localparam int unsigned PHASE_W  = 16;
	localparam int unsigned STEP_W   = 20;
	localparam int unsigned INT_W    = STEP_W + 1 - PHASE_W;
	localparam int unsigned SKIP_W   = 5;
	localparam int unsigned PROD_W   = 25;

	// Most outputs produced from one sample pair.
	localparam int unsigned MAX_OUT = 64;
	localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);

	localparam logic [STEP_W-1:0] STEP_RESET = 20'h10000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_in;      // latch the incoming item
		logic window_step;  // load or skip the incoming byte, no output
		logic step_mul;     // advance phase and form both products
		logic emit_smp;     // load an interpolated sample into the output register
		logic emit_bare;    // load a bare end marker into the output register
	} lisr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pair_ok;   // a held sample is present and nothing is being skipped
		logic last_due;  // the pending sample is the last one of this item
		logic out_free;  // the output register can take a new item
	} lisr_sts_t;

endpackage

### sv/linear_interp_sample_resampler.sv
// Linear interpolation resampler: unsigned 8-bit samples come in on the s_ stream
// (s_tlast marks the final byte of a sound) and signed 16-bit samples leave on the m_
// stream at a rate set by the 4.16 phase step written through cfg_. An input item
// that only fills or skips the window is taken with no output. An item that completes
// a pair is accepted and then gives each output through a multiply stage and then the
// sum into the output register, up to the cap of 64 outputs; the output register
// paces this when m_tready is held low. A final byte without a pair gives one bare
// end marker. m_tlast marks the last output caused by an input item; m_tuser carries
// the sample-valid flag and the end-of-sound flag. Write the phase step only while
// the block is idle.
module linear_interp_sample_resampler (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write: phase step.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [19:0] cfg_data,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] sample_byte
	input  logic        s_tlast,   // final_sample
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] audio_out
	output logic [1:0]  m_tuser,   // [0] sample_valid, [1] sound_end
	output logic        m_tlast    // run_last
);
	import lisr_pkg::*;

	lisr_cmd_t cmd;
	lisr_sts_t sts;

	assign cfg_ready = 1'b1;

	lisr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lisr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.in_byte     (s_tdata),
		.in_fin      (s_tlast),
		.cmd         (cmd),
		.sts         (sts),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_audio     (m_tdata),
		.m_smp_valid (m_tuser[0]),
		.m_run_last  (m_tlast),
		.m_sound_end (m_tuser[1])
	);

endmodule

### sv/lisr_ctrl.sv
module lisr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tlast,
	output logic                  s_tready,
	input  lisr_pkg::lisr_sts_t   sts,
	output lisr_pkg::lisr_cmd_t   cmd
);
	import lisr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_EMIT,
		S_BARE
	} state_t;

	state_t state_q;
	logic   accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Command decode from the current state and status.
	always_comb begin
		cmd             = '0;
		cmd.take_in     = accept;
		cmd.window_step = accept && !sts.pair_ok && !s_tlast;
		cmd.step_mul    = (state_q == S_MUL);
		cmd.emit_smp    = (state_q == S_EMIT) && sts.out_free;
		cmd.emit_bare   = (state_q == S_BARE) && sts.out_free;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (sts.pair_ok) begin
							state_q <= S_MUL;
						end else if (s_tlast) begin
							state_q <= S_BARE;
						end
					end
				end
				S_MUL: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (sts.out_free) begin
						state_q <= sts.last_due ? S_IDLE : S_MUL;
					end
				end
				S_BARE: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/lisr_dp.sv
module lisr_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [lisr_pkg::STEP_W-1:0]       cfg_data,
	input  logic [lisr_pkg::SAMPLE_W-1:0]     in_byte,
	input  logic                              in_fin,
	input  lisr_pkg::lisr_cmd_t               cmd,
	output lisr_pkg::lisr_sts_t               sts,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [lisr_pkg::AUDIO_W-1:0]      m_audio,
	output logic                              m_smp_valid,
	output logic                              m_run_last,
	output logic                              m_sound_end
);
	import lisr_pkg::*;

	logic [STEP_W-1:0]   step_q;
	logic [SAMPLE_W-1:0] held_q;
	logic                have_held_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [SKIP_W-1:0]   skip_q;
	logic [CNT_W-1:0]    n_q;
	logic [SAMPLE_W-1:0] byte_q;
	logic                fin_q;

	logic [INT_W-1:0]         k_s1;
	logic signed [PROD_W-1:0] prod_a_s1;
	logic signed [PROD_W-1:0] prod_b_s1;

	logic                out_valid_q;
	logic [AUDIO_W-1:0]  out_audio_q;
	logic                out_smp_q;
	logic                out_last_q;
	logic                out_end_q;

	logic [STEP_W:0]          phase_sum;
	logic [PHASE_W-1:0]       frac;
	logic signed [PHASE_W:0]  w_cur;
	logic signed [PHASE_W:0]  w_nxt;
	logic signed [SAMPLE_W-1:0] d_cur;
	logic signed [SAMPLE_W-1:0] d_nxt;
	logic signed [PROD_W-1:0] mul_a;
	logic signed [PROD_W-1:0] mul_b;
	logic signed [PROD_W-1:0] interp_sum;
	logic                     last_due;
	logic                     out_load;

	// Phase advance and the two weighted products; samples offset by 0x80.
	assign phase_sum  = {{(STEP_W + 1 - PHASE_W){1'b0}}, phase_q} + {1'b0, step_q};
	assign frac       = phase_sum[PHASE_W-1:0];
	assign w_cur      = $signed({1'b0, ~frac});
	assign w_nxt      = $signed({1'b0, frac});
	assign d_cur      = $signed({~held_q[SAMPLE_W-1], held_q[SAMPLE_W-2:0]});
	assign d_nxt      = $signed({~byte_q[SAMPLE_W-1], byte_q[SAMPLE_W-2:0]});
	assign mul_a      = w_cur * d_cur;
	assign mul_b      = w_nxt * d_nxt;
	assign interp_sum = prod_a_s1 + prod_b_s1;

	assign last_due = (k_s1 != '0) || (n_q == CNT_W'(MAX_OUT));
	assign out_load = cmd.emit_smp || cmd.emit_bare;

	assign sts.pair_ok  = have_held_q && (skip_q == '0);
	assign sts.last_due = last_due;
	assign sts.out_free = !out_valid_q || m_tready;

	// Rate register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_valid) begin
			step_q <= cfg_data;
		end
	end

	// Window state: held sample, phase and skip count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			have_held_q <= 1'b0;
			phase_q     <= '0;
			skip_q      <= '0;
		end else begin
			if (cmd.window_step) begin
				if (skip_q != '0) begin
					skip_q <= skip_q - SKIP_W'(1);
				end else begin
					held_q      <= in_byte;
					have_held_q <= 1'b1;
				end
			end
			if (cmd.step_mul) begin
				phase_q <= frac;
			end
			if (cmd.emit_bare || (cmd.emit_smp && last_due && fin_q)) begin
				held_q      <= '0;
				have_held_q <= 1'b0;
				phase_q     <= '0;
				skip_q      <= '0;
			end else if (cmd.emit_smp && last_due) begin
				if (k_s1 >= INT_W'(2)) begin
					have_held_q <= 1'b0;
					skip_q      <= SKIP_W'(k_s1 - INT_W'(2));
				end else begin
					held_q <= byte_q;
				end
			end
		end
	end

	// Output count for the current pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cmd.take_in) begin
			n_q <= '0;
		end else if (cmd.step_mul) begin
			n_q <= n_q + CNT_W'(1);
		end
	end

	// Incoming item and the multiply stage.
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			byte_q <= in_byte;
			fin_q  <= in_fin;
		end
		if (cmd.step_mul) begin
			k_s1      <= phase_sum[STEP_W:PHASE_W];
			prod_a_s1 <= mul_a;
			prod_b_s1 <= mul_b;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; the floor shift by 8 keeps bits 23 to 8.
	always_ff @(posedge clk) begin
		if (cmd.emit_smp) begin
			out_audio_q <= interp_sum[AUDIO_W+7:8];
			out_smp_q   <= 1'b1;
			out_last_q  <= last_due;
			out_end_q   <= last_due && fin_q;
		end else if (cmd.emit_bare) begin
			out_audio_q <= '0;
			out_smp_q   <= 1'b0;
			out_last_q  <= 1'b1;
			out_end_q   <= 1'b1;
		end
	end

	assign m_tvalid    = out_valid_q;
	assign m_audio     = out_audio_q;
	assign m_smp_valid = out_smp_q;
	assign m_run_last  = out_last_q;
	assign m_sound_end = out_end_q;

	// The output register is loaded only when it is empty or being drained.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_tready))
		else $error("output register overwritten while still held");

	// A nonzero skip count only exists while the window is empty.
	a_skip_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(skip_q != '0) |-> !have_held_q)
		else $error("skip count set while a sample is held");

	// The end of a sound leaves the window state cleared.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_bare || (cmd.emit_smp && last_due && fin_q)) |=>
		(!have_held_q && (phase_q == '0) && (skip_q == '0) && (held_q == '0)))
		else $error("state not cleared after end of sound");

	// Never more outputs from one pair than the cap.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_OUT))
		else $error("output count exceeds cap");

endmodule

### sim/linear_interp_sample_resampler_test.sv
`timescale 1ns / 100ps

module linear_interp_sample_resampler_test;

	import lisr_pkg::*;

	localparam int FULL_WEIGHT   = 65535;
	localparam int SILENCE       = 128;
	localparam int SKIP_MASK     = 31;
	localparam int IDLE_PCT      = 7;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 200;
	localparam int STALL_LIMIT   = 3000;
	localparam int RANDOM_ITEMS  = 320;
	localparam int PRINT_LIMIT   = 30;

	// One output item as the block presents it.
	typedef struct packed {
		logic [AUDIO_W-1:0] audio;
		logic               sample_valid;
		logic               run_last;
		logic               sound_end;
	} resample_out_t;

	// Tracks the resampler state and the output items still owed by the block.
	class resample_scoreboard;
		logic [STEP_W-1:0]   step;
		logic [SAMPLE_W-1:0] held;
		logic                have_held;
		logic [PHASE_W-1:0]  frac;
		logic [SKIP_W-1:0]   skip;
		resample_out_t       due[$];
		int                  mismatches;
		int                  results_seen;
		int                  bare_markers;
		int                  longest_burst;

		function new();
			step = STEP_RESET;
			clear_window();
			mismatches = 0;
			results_seen = 0;
			bare_markers = 0;
			longest_burst = 0;
		endfunction

		function void clear_window();
			held = '0;
			have_held = 1'b0;
			frac = '0;
			skip = '0;
		endfunction

		function void set_step(logic [STEP_W-1:0] value);
			step = value;
		endfunction

		// Weighted sum of the two offset samples, floored by 256.
		function logic [AUDIO_W-1:0] blend(logic [SAMPLE_W-1:0] cur, logic [SAMPLE_W-1:0] nxt,
				logic [PHASE_W-1:0] f);
			int a;
			int b;
			int w;
			int v;
			a = int'(cur) - SILENCE;
			b = int'(nxt) - SILENCE;
			w = int'(f);
			v = (FULL_WEIGHT - w) * a + w * b;
			return AUDIO_W'(v >>> 8);
		endfunction

		// Work out the output items caused by one accepted input item.
		function void note_input(logic [SAMPLE_W-1:0] sample, logic last_byte);
			int unsigned p;
			int unsigned k;
			int n;
			bit done;
			resample_out_t r;
			if (!have_held || skip != 0) begin
				if (last_byte) begin
					r = '{audio: '0, sample_valid: 1'b0, run_last: 1'b1, sound_end: 1'b1};
					due.push_back(r);
					bare_markers++;
					clear_window();
				end else if (skip != 0) begin
					skip = skip - 1'b1;
				end else begin
					held = sample;
					have_held = 1'b1;
				end
				return;
			end
			n = 0;
			k = 0;
			done = 1'b0;
			while (!done) begin
				p = frac + step;
				frac = p[PHASE_W-1:0];
				k = p >> PHASE_W;
				n++;
				done = (k != 0) || (n == MAX_OUT);
				r.audio = blend(held, sample, frac);
				r.sample_valid = 1'b1;
				r.run_last = done;
				r.sound_end = done && last_byte;
				due.push_back(r);
			end
			if (n > longest_burst)
				longest_burst = n;
			if (last_byte) begin
				clear_window();
			end else if (k >= 2) begin
				have_held = 1'b0;
				skip = SKIP_W'((k - 2) & SKIP_MASK);
			end else begin
				held = sample;
			end
		endfunction

		task report_mismatch(string msg);
			if (mismatches < PRINT_LIMIT)
				$display("mismatch at %0t: %s", $time, msg);
			mismatches++;
		endtask

		// Compare one output item with the oldest one owed.
		task check_result(resample_out_t got);
			resample_out_t want;
			if (due.size() == 0) begin
				report_mismatch($sformatf("output item with nothing owed, audio %0d",
					$signed(got.audio)));
				return;
			end
			want = due.pop_front();
			results_seen++;
			if (got.audio !== want.audio)
				report_mismatch($sformatf("audio_out %0d, expected %0d",
					$signed(got.audio), $signed(want.audio)));
			if (got.sample_valid !== want.sample_valid)
				report_mismatch($sformatf("sample_valid %b, expected %b",
					got.sample_valid, want.sample_valid));
			if (got.run_last !== want.run_last)
				report_mismatch($sformatf("run_last %b, expected %b",
					got.run_last, want.run_last));
			if (got.sound_end !== want.sound_end)
				report_mismatch($sformatf("sound_end %b, expected %b",
					got.sound_end, want.sound_end));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [STEP_W-1:0]   cfg_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata = '0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [AUDIO_W-1:0]  m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	resample_scoreboard sb;
	bit                 steady = 1'b0;
	int                 items_sent = 0;
	int                 steps_used = 0;
	int                 quiet_cycles = 0;
	resample_out_t      seen;

	linear_interp_sample_resampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver stalls at random except during the steady stretch.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Check every output item that the receiver takes.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen.audio = m_tdata;
			seen.sample_valid = m_tuser[0];
			seen.run_last = m_tlast;
			seen.sound_end = m_tuser[1];
			sb.check_result(seen);
		end
	end

	// End the run if nothing moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles with no handshake", quiet_cycles);
				$display("linear_interp_sample_resampler regression: fail");
				$finish;
			end
		end
	end

	// Present one sample, idling at random first, and wait for it to be taken.
	task send_item(logic [SAMPLE_W-1:0] sample, logic last_byte);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= sample;
		s_tlast <= last_byte;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(sample, last_byte);
		items_sent++;
	endtask

	// Hold the sender until every owed output item has arrived, then let the block settle.
	task drain_output();
		s_tvalid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the phase step; the block must be idle.
	task write_step(logic [STEP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_step(value);
		steps_used++;
	endtask

	function logic [STEP_W-1:0] pick_step();
		case ($urandom_range(0, 5))
			0: return 20'd1024;
			1: return 20'hFFFFF;
			2: return STEP_RESET;
			3: return STEP_W'($urandom_range(1024, 20'h1FFFF));
			4: return STEP_W'($urandom_range(20'h20000, 20'hFFFFF));
			default: return STEP_W'($urandom_range(1024, 20'hFFFFF));
		endcase
	endfunction

	function logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			default: return SAMPLE_W'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int random_items;
		int phase;
		int run_len;
		sb = new();
		random_items = 0;
		phase = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset step of one: a bare end marker on an empty window, then the output extremes.
		send_item(8'h80, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b1);

		// Step of one and a half: the window alternately moves by one and by two.
		drain_output();
		write_step(20'h18000);
		send_item(8'h10, 1'b0);
		send_item(8'h20, 1'b0);
		send_item(8'h30, 1'b0);
		send_item(8'h40, 1'b0);
		send_item(8'h50, 1'b0);
		send_item(8'h60, 1'b1);

		// Smallest step: the longest burst from one pair, also on the final byte.
		drain_output();
		write_step(20'd1024);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);

		// Largest step: bytes are skipped, and the sound ends while skipping.
		drain_output();
		write_step(20'hFFFFF);
		send_item(8'h80, 1'b0);
		send_item(8'h7F, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'hFE, 1'b1);

		// Half step: two outputs from each pair.
		drain_output();
		write_step(20'h08000);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h55, 1'b1);

		// Random phases, each with its own step; the second runs without any idling.
		while (random_items < RANDOM_ITEMS) begin
			drain_output();
			write_step(pick_step());
			steady = (phase == 1);
			run_len = $urandom_range(30, 50);
			for (int i = 0; i < run_len; i++) begin
				if (phase == 2 && i == run_len / 2)
					drain_output();
				send_item(pick_sample(), $urandom_range(0, 11) == 0);
				random_items++;
			end
			phase++;
		end
		steady = 1'b0;

		s_tvalid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d input items over %0d phase-step settings", items_sent, steps_used);
		$display("checked %0d output items, %0d of them bare end markers, longest burst %0d",
			sb.results_seen, sb.bare_markers, sb.longest_burst);
		if (sb.mismatches == 0 && sb.due.size() == 0) begin
			$display("linear_interp_sample_resampler regression: pass");
		end else begin
			$display("linear_interp_sample_resampler regression: fail");
		end
		$finish;
	end

endmodule
